// File: src/assert_macros.svh
// Assertion macros shared by the FAT chain walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define FCOS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define FCOS_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

// File: src/fcos_pkg.sv
// Types, codes and constants for the FAT chain offset-to-sector block.
package fcos_pkg;

    // operation codes (s_tuser[0])
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_FAT12_MODE    = 3'd0;
    localparam logic [2:0] REG_CLUSTER_SHIFT = 3'd1;
    localparam logic [2:0] REG_N_CLUSTERS    = 3'd2;
    localparam logic [2:0] REG_ROOT_BASE     = 3'd3;
    localparam logic [2:0] REG_ROOT_SIZE     = 3'd4;
    localparam logic [2:0] REG_DATA_BASE     = 3'd5;

    localparam int          SECTOR_SHIFT = 9;
    localparam logic [15:0] END12        = 16'hFF8;
    localparam logic [15:0] END16        = 16'hFFF8;
    localparam logic [11:0] MASK12       = 12'hFFF;

    typedef struct packed {
        logic        fat12_mode;
        logic [2:0]  cluster_shift;
        logic [15:0] n_clusters;
        logic [31:0] root_base;
        logic [20:0] root_size;
        logic [31:0] data_base;
    } cfg_t;

    typedef struct packed {
        logic        root_region;
        logic [15:0] start_cluster;
        logic [31:0] byte_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sector_number;
    } res_t;

    // cluster lies in 2 .. count+1
    function automatic logic cluster_ok(logic [15:0] c, logic [15:0] count);
        return (c >= 16'd2) && ({1'b0, c} < ({1'b0, count} + 17'd2));
    endfunction

endpackage

// File: src/fcos_table_mem.sv
// Allocation table store: even and odd byte banks, 16-bit reads at any byte address.
module fcos_table_mem #(
    parameter int TABLE_BYTES = 131072
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(TABLE_BYTES)-1:0] waddr,
    input  logic [7:0]                     wdata,
    input  logic                           re,
    input  logic [$clog2(TABLE_BYTES)-1:0] raddr,
    output logic [15:0]                    rdata
);
    localparam int AW  = $clog2(TABLE_BYTES);
    localparam int D0  = (TABLE_BYTES + 1) / 2;
    localparam int D1  = TABLE_BYTES / 2;
    localparam int IW0 = (D0 > 1) ? $clog2(D0) : 1;
    localparam int IW1 = (D1 > 1) ? $clog2(D1) : 1;

    logic [7:0] bank0_mem [D0];
    logic [7:0] bank1_mem [D1];

    logic [7:0] rd0_reg;
    logic [7:0] rd1_reg;
    logic       odd_reg;

    logic [AW:0]  waddr_half;
    logic [AW:0]  raddr_half;
    logic [AW:0]  raddr_up;

    assign waddr_half = {1'b0, waddr} >> 1;
    assign raddr_half = {1'b0, raddr} >> 1;
    // even bank holds the byte at raddr (even) or raddr+1 (odd)
    assign raddr_up   = ({1'b0, raddr} + (AW+1)'(1)) >> 1;

    always_ff @(posedge clk)
    begin
        if (we && !waddr[0])
        begin
            bank0_mem[waddr_half[IW0-1:0]] <= wdata;
        end
        if (we && waddr[0])
        begin
            bank1_mem[waddr_half[IW1-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd0_reg <= bank0_mem[raddr_up[IW0-1:0]];
            rd1_reg <= bank1_mem[raddr_half[IW1-1:0]];
            odd_reg <= raddr[0];
        end
    end

    assign rdata = odd_reg ? {rd0_reg, rd1_reg} : {rd1_reg, rd0_reg};

endmodule

// File: src/fcos_walker.sv
// Chain walk sequencer: reads one table entry per step and forms the sector.
`include "assert_macros.svh"

module fcos_walker #(
    parameter int TABLE_BYTES = 131072
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fcos_pkg::cfg_t                 cfg,
    input  logic                           start,
    input  fcos_pkg::req_t                 req,
    output logic                           idle,
    output logic                           rd_en,
    output logic [$clog2(TABLE_BYTES)-1:0] rd_addr,
    input  logic [15:0]                    rd_data,
    output logic                           res_valid,
    input  logic                           res_ready,
    output fcos_pkg::res_t                 res
);
    localparam int AW = $clog2(TABLE_BYTES);
    localparam logic [17:0] LAST_LOW = 18'(TABLE_BYTES - 1);
    localparam int SECTOR_SHIFT_L = fcos_pkg::SECTOR_SHIFT;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_BASE  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]  state_reg,  state_next;
    logic        root_reg,   root_next;
    logic [15:0] cur_reg,    cur_next;
    logic [31:0] off_reg,    off_next;
    logic [22:0] rem_reg,    rem_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] sector_reg, sector_next;

    logic [22:0] index;
    logic [17:0] entry_addr;
    logic [15:0] link;
    logic        link_end;
    logic [31:0] cl_off;
    logic [22:0] sec_in_cl;

    assign index      = off_reg[31:SECTOR_SHIFT_L] >> cfg.cluster_shift;
    assign entry_addr = cfg.fat12_mode ? ({2'b00, cur_reg} + {3'b000, cur_reg[15:1]})
                                       : {1'b0, cur_reg, 1'b0};
    assign link       = !cfg.fat12_mode ? rd_data
                      : cur_reg[0]      ? {4'h0, rd_data[15:4]}
                                        : {4'h0, rd_data[11:0] & fcos_pkg::MASK12};
    assign link_end   = cfg.fat12_mode ? (link >= fcos_pkg::END12)
                                       : (link >= fcos_pkg::END16);
    assign cl_off     = {16'h0000, cur_reg - 16'd2} << cfg.cluster_shift;
    assign sec_in_cl  = off_reg[31:SECTOR_SHIFT_L]
                        & ((23'd1 << cfg.cluster_shift) - 23'd1);

    always_comb
    begin
        state_next  = state_reg;
        root_next   = root_reg;
        cur_next    = cur_reg;
        off_next    = off_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        sector_next = sector_reg;
        rd_en       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    root_next  = req.root_region;
                    cur_next   = req.start_cluster;
                    off_next   = req.byte_offset;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                sector_next = 32'h0;
                if (root_reg)
                begin
                    state_next = S_ROOT;
                end
                else if (cur_reg == 16'd0)
                begin
                    status_next = fcos_pkg::ST_END;
                    state_next  = S_DONE;
                end
                else if (!fcos_pkg::cluster_ok(cur_reg, cfg.n_clusters))
                begin
                    status_next = fcos_pkg::ST_ERR;
                    state_next  = S_DONE;
                end
                else
                begin
                    rem_next   = index;
                    state_next = (index == 23'd0) ? S_BASE : S_STEP;
                end
            end
            S_ROOT:
            begin
                if (off_reg >= {11'h000, cfg.root_size})
                begin
                    status_next = fcos_pkg::ST_END;
                end
                else
                begin
                    status_next = fcos_pkg::ST_OK;
                    sector_next = cfg.root_base + {9'h000, off_reg[31:SECTOR_SHIFT_L]};
                end
                state_next = S_DONE;
            end
            S_STEP:
            begin
                if (rem_reg > {7'h00, cfg.n_clusters} || entry_addr >= LAST_LOW)
                begin
                    status_next = fcos_pkg::ST_ERR;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (link_end)
                begin
                    status_next = fcos_pkg::ST_END;
                    state_next  = S_DONE;
                end
                else if (!fcos_pkg::cluster_ok(link, cfg.n_clusters))
                begin
                    status_next = fcos_pkg::ST_ERR;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = link;
                    rem_next   = rem_reg - 23'd1;
                    state_next = (rem_reg == 23'd1) ? S_BASE : S_STEP;
                end
            end
            S_BASE:
            begin
                sector_next = cfg.data_base + cl_off;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                sector_next = sector_reg + {9'h000, sec_in_cl};
                status_next = fcos_pkg::ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg   <= root_next;
        cur_reg    <= cur_next;
        off_reg    <= off_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
        sector_reg <= sector_next;
    end

    assign rd_addr           = entry_addr[AW-1:0];
    assign idle              = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_DONE);
    assign res.status        = status_reg;
    assign res.sector_number = sector_reg;

    `FCOS_ASSERT(a_check_after_read, clk, rst_n,
                 (state_reg == S_CHECK |-> $past(state_reg) == S_STEP && $past(rd_en)))
    `FCOS_NEVER(a_step_with_no_work, clk, rst_n,
                (state_reg == S_STEP && rem_reg == 23'd0))
    `FCOS_NEVER(a_fail_has_sector, clk, rst_n,
                (res_valid && status_reg != fcos_pkg::ST_OK && sector_reg != 32'h0))

endmodule

// File: src/fat_chain_offset_to_sector.sv
// Top level: FAT12/16 cluster chain walk from byte offset to disk sector.
//
// Input channel s_*: one transfer is either a table load (s_tuser[0] = 0),
// which writes one allocation table byte and gives no result, or a
// translate (s_tuser[0] = 1), which gives exactly one result on m_*.
// Result channel m_*: status in m_tuser, sector number in m_tdata.
// Configuration: cfg_we/cfg_index/cfg_data write one register per edge;
// the user writes them only while no translate is outstanding, as the
// block itself has no check for it. A root region translate compares
// the offset with the root size and forms the sector; an empty file or
// a bad start cluster gives its status with no walk; a file translate
// follows the chain one link at a time, each link being one table read
// (registered data) and a decode and check of it, then forms the sector.
// The next item is taken in the cycle after the result is handed to the
// output register.
// The output register parts the two sides: while a result waits for
// m_tready, one more translate can be walked and then holds in the
// sequencer until the register frees up; s_tready is low meanwhile.
// Reset clears the control state and the configuration registers to
// zero; the table contents are undefined until loaded.
`include "assert_macros.svh"

module fat_chain_offset_to_sector #(
    parameter int TABLE_BYTES = 131072
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [16:0] table_address, [24:17] table_byte, [40:25] start_cluster,
    // [72:41] byte_offset, [79:73] zero
    input  logic [79:0] s_tdata,
    // [0] operation, [1] root_region
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] sector_number
    output logic [31:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int AW = $clog2(TABLE_BYTES);

    fcos_pkg::cfg_t cfg_reg;
    fcos_pkg::req_t req;
    fcos_pkg::res_t res;

    logic        m_valid_reg;
    fcos_pkg::res_t m_res_reg;

    logic        in_xfer;
    logic        load_we;
    logic        walk_idle;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0] rd_data;
    logic        res_valid;
    logic        res_ready;
    logic [16:0] table_address;

    assign table_address     = s_tdata[16:0];
    assign req.start_cluster = s_tdata[40:25];
    assign req.byte_offset   = s_tdata[72:41];
    assign req.root_region   = s_tuser[1];

    assign s_tready = walk_idle;
    assign in_xfer  = s_tvalid && s_tready;
    // loads beyond the table are dropped
    assign load_we  = in_xfer && (s_tuser[0] == fcos_pkg::OP_LOAD)
                      && ({1'b0, table_address} < 18'(TABLE_BYTES));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fcos_pkg::REG_FAT12_MODE:    cfg_reg.fat12_mode    <= cfg_data[0];
                fcos_pkg::REG_CLUSTER_SHIFT: cfg_reg.cluster_shift <= cfg_data[2:0];
                fcos_pkg::REG_N_CLUSTERS:    cfg_reg.n_clusters    <= cfg_data[15:0];
                fcos_pkg::REG_ROOT_BASE:     cfg_reg.root_base     <= cfg_data;
                fcos_pkg::REG_ROOT_SIZE:     cfg_reg.root_size     <= cfg_data[20:0];
                fcos_pkg::REG_DATA_BASE:     cfg_reg.data_base     <= cfg_data;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    fcos_table_mem #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_mem (
        .clk  (clk),
        .we   (load_we),
        .waddr(table_address[AW-1:0]),
        .wdata(s_tdata[24:17]),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    fcos_walker #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (in_xfer && (s_tuser[0] == fcos_pkg::OP_XLATE)),
        .req      (req),
        .idle     (walk_idle),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.sector_number;
    assign m_tuser  = m_res_reg.status;

    `FCOS_ASSERT(a_xlate_blocks_input, clk, rst_n,
                 (in_xfer && s_tuser[0] == fcos_pkg::OP_XLATE |=> !s_tready))
    `FCOS_NEVER(a_load_during_walk, clk, rst_n, (load_we && !walk_idle))
    `FCOS_ASSERT(a_out_holds, clk, rst_n,
                 (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule
